/* rtl/core/frustum_chunk_column_cull_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the frustum chunk column cull block
// Wraps concurrent assertions so that a build can drop them as a group.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_CHUNK_COLUMN_CULL_DEFINES_SVH
`define FRUSTUM_CHUNK_COLUMN_CULL_DEFINES_SVH

`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define FCCC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fccc assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define FCCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fccc assertion failed");
`else
`define FCCC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define FCCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/core/fccc_pkg.sv */
// ----------------------------------------------------------------------------
// fccc_pkg
// Types and fixed widths shared by the frustum chunk column cull modules.
// ----------------------------------------------------------------------------
package fccc_pkg;

    localparam int ENTRY_W    = 32;  // Q16.16 matrix entry
    localparam int INDEX_W    = 4;   // column*4+row
    localparam int CHUNK_W    = 20;  // chunk column coordinate
    localparam int COORD_W    = 30;  // box coordinate
    localparam int PLANE_W    = ENTRY_W + 1;
    localparam int PROD_W     = PLANE_W + COORD_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int NUM_PLANES = 6;
    localparam int NUM_COLS   = 4;
    localparam int NUM_AXES   = 3;

    // Row 3 of the matrix is the one every plane combines with.
    localparam logic [1:0] W_ROW = 2'd3;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_TEST = 1'b1
    } func_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        func_t                      func;
        logic [INDEX_W-1:0]         entry_index;
        logic [ENTRY_W-1:0]         entry_value;
        coord_t [NUM_AXES-1:0]      box_lo;
        coord_t [NUM_AXES-1:0]      box_hi;
        logic                       vis;
    } item_t;

endpackage

/* rtl/core/frustum_chunk_column_cull.sv */
// ----------------------------------------------------------------------------
// frustum_chunk_column_cull
// Frustum culling of chunk column boxes against a loaded 4x4 matrix.
// ----------------------------------------------------------------------------
// The input channel (s_valid/s_ready) carries two kinds of item. With s_func
// low, the item writes one Q16.16 matrix entry, s_entry_index = column*4+row,
// and produces no result. With s_func high, the item tests the chunk column
// at (s_chunk_x, s_chunk_z) and produces exactly one result item on the
// m_valid/m_ready channel: m_visible is high unless the column's box lies
// fully outside one of the six frustum planes.
// The datapath is a box stage followed by a row of six plane cells, one per
// plane, each two registers deep. A test result is offered on m_valid once
// its item reaches the end of the row, and one item is accepted every cycle
// while s_ready is high. Each cell holds its own copy of the matrix entries
// that its plane uses; a load travels down the row and updates each copy as
// it passes, so every item sees exactly the matrix written by the loads
// accepted before it. Reset clears the matrix to all zeros and empties the
// row. When the receiver holds m_ready low, the row keeps filling its empty
// stages and s_ready falls only once every stage holds an item.
// ----------------------------------------------------------------------------
`include "frustum_chunk_column_cull_defines.svh"

module frustum_chunk_column_cull #(
    parameter int CHUNK_LENGTH = 16,
    parameter int CHUNK_WIDTH  = 16,
    parameter int CHUNK_HEIGHT = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_func,
    input  logic [fccc_pkg::INDEX_W-1:0]        s_entry_index,
    input  logic signed [fccc_pkg::ENTRY_W-1:0] s_entry_value,
    input  logic signed [fccc_pkg::CHUNK_W-1:0] s_chunk_x,
    input  logic signed [fccc_pkg::CHUNK_W-1:0] s_chunk_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_visible
);
    import fccc_pkg::*;

    // Register stages an item passes through: the box stage and two per cell.
    localparam int STAGES = 1 + 2 * NUM_PLANES;
    localparam int CNT_W  = $clog2(STAGES + 1);

    logic  chain_valid [NUM_PLANES+1];
    logic  chain_ready [NUM_PLANES+1];
    item_t chain_item  [NUM_PLANES+1];

    // The box stage registers the item and works out its box corners.
    fccc_box #(
        .CHUNK_LENGTH (CHUNK_LENGTH),
        .CHUNK_WIDTH  (CHUNK_WIDTH),
        .CHUNK_HEIGHT (CHUNK_HEIGHT)
    ) u_box (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .func        (func_t'(s_func)),
        .entry_index (s_entry_index),
        .entry_value (s_entry_value),
        .chunk_x     (s_chunk_x),
        .chunk_z     (s_chunk_z),
        .out_valid   (chain_valid[0]),
        .out_ready   (chain_ready[0]),
        .out_item    (chain_item[0])
    );

    // One cell per plane; each clears the visible flag if its plane rejects
    // the box.
    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
        fccc_cell #(
            .PLANE (p)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[p]),
            .in_ready  (chain_ready[p]),
            .in_item   (chain_item[p]),
            .out_valid (chain_valid[p+1]),
            .out_ready (chain_ready[p+1]),
            .out_item  (chain_item[p+1])
        );
    end

    // Load items leave the row without a result; test items become results.
    assign m_valid   = chain_valid[NUM_PLANES] && (chain_item[NUM_PLANES].func == FUNC_TEST);
    assign m_visible = chain_item[NUM_PLANES].vis;
    assign chain_ready[NUM_PLANES] = m_ready || (chain_item[NUM_PLANES].func == FUNC_LOAD);

    // Count of test items accepted whose result has not yet been taken.
    logic [CNT_W-1:0] tests_reg;
    logic [CNT_W-1:0] tests_next;
    logic             test_in;
    logic             test_out;

    assign test_in  = s_valid && s_ready && (s_func == FUNC_TEST);
    assign test_out = m_valid && m_ready;

    always_comb begin
        tests_next = tests_reg;
        if (test_in && !test_out) begin
            tests_next = tests_reg + CNT_W'(1);
        end else if (!test_in && test_out) begin
            tests_next = tests_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tests_reg <= '0;
        end else begin
            tests_reg <= tests_next;
        end
    end

    // A result can only leave if a test item is actually in flight.
    `FCCC_ASSERT_IMPL(a_result_has_test, aclk, aresetn, m_valid, tests_reg != '0)
    // The row never holds more items than it has register stages.
    `FCCC_ASSERT_IMPL(a_tests_bounded, aclk, aresetn, 1'b1, tests_reg <= CNT_W'(STAGES))
    // Back-pressure on the input can only come from a stalled result.
    `FCCC_ASSERT_IMPL(a_stall_cause, aclk, aresetn, !s_ready, m_valid && !m_ready)
    // A stalled result stays offered, unchanged, on the next cycle.
    `FCCC_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_visible))

endmodule

/* rtl/core/fccc_box.sv */
// ----------------------------------------------------------------------------
// fccc_box
// Entry stage: turns a chunk column coordinate into its box corners.
// ----------------------------------------------------------------------------
module fccc_box #(
    parameter int CHUNK_LENGTH = 16,
    parameter int CHUNK_WIDTH  = 16,
    parameter int CHUNK_HEIGHT = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  fccc_pkg::func_t                 func,
    input  logic [fccc_pkg::INDEX_W-1:0]    entry_index,
    input  logic [fccc_pkg::ENTRY_W-1:0]    entry_value,
    input  logic signed [fccc_pkg::CHUNK_W-1:0] chunk_x,
    input  logic signed [fccc_pkg::CHUNK_W-1:0] chunk_z,
    output logic                            out_valid,
    input  logic                            out_ready,
    output fccc_pkg::item_t                 out_item
);
    import fccc_pkg::*;

    localparam coord_t LEN_C = COORD_W'(CHUNK_LENGTH);
    localparam coord_t WID_C = COORD_W'(CHUNK_WIDTH);
    localparam coord_t HGT_C = COORD_W'(CHUNK_HEIGHT);

    logic   valid_reg;
    logic   valid_next;
    item_t  item_reg;
    item_t  item_next;
    coord_t cx_ext;
    coord_t cz_ext;
    coord_t lo_x;
    coord_t lo_z;
    logic   take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    assign cx_ext = {{(COORD_W-CHUNK_W){chunk_x[CHUNK_W-1]}}, chunk_x};
    assign cz_ext = {{(COORD_W-CHUNK_W){chunk_z[CHUNK_W-1]}}, chunk_z};
    assign lo_x   = cx_ext * LEN_C;
    assign lo_z   = cz_ext * WID_C;

    always_comb begin
        item_next             = item_reg;
        valid_next            = take || (valid_reg && !out_ready);
        if (take) begin
            item_next.func        = func;
            item_next.entry_index = entry_index;
            item_next.entry_value = entry_value;
            item_next.box_lo[0]   = lo_x;
            item_next.box_hi[0]   = lo_x + LEN_C;
            item_next.box_lo[1]   = '0;
            item_next.box_hi[1]   = HGT_C;
            item_next.box_lo[2]   = lo_z;
            item_next.box_hi[2]   = lo_z + WID_C;
            item_next.vis         = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* rtl/core/fccc_cell.sv */
// ----------------------------------------------------------------------------
// fccc_cell
// One plane of the frustum: keeps its own copy of the matrix entries it needs
// and tests each passing item against that plane in two stages.
// ----------------------------------------------------------------------------
module fccc_cell #(
    parameter int PLANE = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  fccc_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output fccc_pkg::item_t out_item
);
    import fccc_pkg::*;

    // Planes come in pairs per axis: even adds the axis row, odd subtracts it.
    localparam logic [1:0] AXIS  = 2'(PLANE / 2);
    localparam bit         MINUS = (PLANE % 2) == 1;

    logic [ENTRY_W-1:0]        col3_reg  [NUM_COLS];
    logic [ENTRY_W-1:0]        col3_next [NUM_COLS];
    logic [ENTRY_W-1:0]        colk_reg  [NUM_COLS];
    logic [ENTRY_W-1:0]        colk_next [NUM_COLS];

    logic signed [PLANE_W-1:0] plane_c  [NUM_COLS];
    logic signed [COORD_W-1:0] corner_c [NUM_AXES];
    logic signed [PROD_W-1:0]  prod_c   [NUM_AXES];

    logic                      a_valid_reg;
    logic                      a_valid_next;
    item_t                     a_item_reg;
    logic signed [PROD_W-1:0]  a_prod_reg [NUM_AXES];
    logic signed [PLANE_W-1:0] a_off_reg;

    logic                      b_valid_reg;
    logic                      b_valid_next;
    item_t                     b_item_reg;
    item_t                     b_item_next;

    logic                      b_free;
    logic                      take;
    logic                      load_take;
    logic [1:0]                ld_col;
    logic [1:0]                ld_row;
    logic signed [SUM_W-1:0]   plane_sum;

    assign b_free    = !b_valid_reg || out_ready;
    assign in_ready  = !a_valid_reg || b_free;
    assign take      = in_valid && in_ready;
    assign load_take = take && (in_item.func == FUNC_LOAD);
    assign ld_col    = in_item.entry_index[3:2];
    assign ld_row    = in_item.entry_index[1:0];

    // A load updates this cell's copy as it passes, so later tests see it and
    // tests already past this cell do not.
    always_comb begin
        col3_next = col3_reg;
        colk_next = colk_reg;
        if (load_take) begin
            if (ld_row == W_ROW) begin
                col3_next[ld_col] = in_item.entry_value;
            end
            if (ld_row == AXIS) begin
                colk_next[ld_col] = in_item.entry_value;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_COLS; c++) begin
            if (MINUS) begin
                plane_c[c] = $signed({col3_reg[c][ENTRY_W-1], col3_reg[c]})
                           - $signed({colk_reg[c][ENTRY_W-1], colk_reg[c]});
            end else begin
                plane_c[c] = $signed({col3_reg[c][ENTRY_W-1], col3_reg[c]})
                           + $signed({colk_reg[c][ENTRY_W-1], colk_reg[c]});
            end
        end
        // Positive vertex: a zero component takes the upper corner.
        for (int c = 0; c < NUM_AXES; c++) begin
            corner_c[c] = plane_c[c][PLANE_W-1] ? $signed(in_item.box_lo[c])
                                                : $signed(in_item.box_hi[c]);
            prod_c[c]   = plane_c[c] * corner_c[c];
        end
    end

    assign a_valid_next = take || (a_valid_reg && !b_free);
    assign b_valid_next = (a_valid_reg && b_free) || (b_valid_reg && !out_ready);

    assign plane_sum = SUM_W'(a_prod_reg[0]) + SUM_W'(a_prod_reg[1])
                     + SUM_W'(a_prod_reg[2]) + SUM_W'(a_off_reg);

    always_comb begin
        b_item_next = b_item_reg;
        if (a_valid_reg && b_free) begin
            b_item_next = a_item_reg;
            if (a_item_reg.func == FUNC_TEST) begin
                b_item_next.vis = a_item_reg.vis && !plane_sum[SUM_W-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_COLS; c++) begin
                col3_reg[c] <= '0;
                colk_reg[c] <= '0;
            end
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            col3_reg    <= col3_next;
            colk_reg    <= colk_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            a_item_reg <= in_item;
            a_off_reg  <= plane_c[W_ROW];
            for (int c = 0; c < NUM_AXES; c++) begin
                a_prod_reg[c] <= prod_c[c];
            end
        end
        b_item_reg <= b_item_next;
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

endmodule
